FILE: rtl/bwa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bwa_pkg;

   // Fixed sample format: signed Q8.8.
   localparam int SAMPLE_WIDTH = 16;
   // Result carries +/- alpha, and alpha can reach 2^(SAMPLE_WIDTH-1).
   localparam int SCALED_WIDTH = SAMPLE_WIDTH + 1;
   // Default capacity of one set.
   localparam int MAX_ELEMS_DEFAULT = 64;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample;
      logic                           last_in;
   } req_type;

   typedef struct packed {
      logic signed [SCALED_WIDTH-1:0] scaled;
      logic                           positive;
      logic                           last_out;
      logic                           overflowed;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_EMIT,
      ST_DRAIN
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/binary_weight_approximation_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel    | Ports                      | Handshake
// -----------+----------------------------+------------------------------------
// request    | start, busy, req_data      | taken at a clock edge with start=1, busy=0
// result     | rsp_strobe, rsp_data       | one cycle per result, no back-pressure
//
// Sequence: each request of a set is stored as it is taken, up to capacity. The
//   request marked last starts the end-of-set pass: the divider is loaded and
//   runs a bit-serial divide of the SUM_W-bit sum (22 bits at the defaults),
//   alpha is latched, then one result per cycle comes from the sign memory read
//   port, followed by a drain state that clears the set.
// Reset: synchronous, active high; clears sum, count, overflow flag and the
//   sequencer. The sign memory is not cleared; only entries of the current set
//   are read.
// Stalls: busy is high from the last request until the final result has been
//   shown. The receiver cannot stall, so the emit phase never waits.
module binary_weight_approximation_top #(
   parameter int MAX_ELEMS = bwa_pkg::MAX_ELEMS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire bwa_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output bwa_pkg::rsp_type      rsp_data
);

   localparam int SW     = bwa_pkg::SAMPLE_WIDTH;
   localparam int CNT_W  = $clog2(MAX_ELEMS + 1);
   localparam int ADDR_W = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
   // Largest sum is MAX_ELEMS * 2^(SW-1).
   localparam int SUM_W  = SW + ((MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 0);

   bwa_pkg::state_type state_ff, state_in;

   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             rd_valid_ff, rd_valid_in;
   logic             rd_last_ff, rd_last_in;
   logic [SW-1:0]    alpha_ff, alpha_in;
   logic             sign_q_ff;

   logic             sign_mem [MAX_ELEMS];

   logic             accept;
   logic             room;
   logic             sample_neg;
   logic [SW-1:0]    sample_mag;
   logic             last_read;

   logic             div_start;
   logic             rd_en;
   logic             set_clear;

   logic             div_done;
   logic [SUM_W-1:0] div_quotient;

   logic [SW:0]      alpha_ext;

   assign accept = start && !busy;
   assign room   = count_ff < CNT_W'(MAX_ELEMS);

   // Zero counts as positive; the most negative sample maps to 2^(SW-1).
   assign sample_neg = req_data.sample[SW-1];
   assign sample_mag = sample_neg ? (~req_data.sample + SW'(1)) : req_data.sample;

   assign last_read = rd_idx_ff == (count_ff - CNT_W'(1));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bwa_pkg::ST_IDLE: begin
            if (accept && req_data.last_in) state_in = bwa_pkg::ST_DIV_START;
         end
         bwa_pkg::ST_DIV_START: begin
            state_in = bwa_pkg::ST_DIV_WAIT;
         end
         bwa_pkg::ST_DIV_WAIT: begin
            if (div_done) state_in = bwa_pkg::ST_EMIT;
         end
         bwa_pkg::ST_EMIT: begin
            if (last_read) state_in = bwa_pkg::ST_DRAIN;
         end
         bwa_pkg::ST_DRAIN: begin
            state_in = bwa_pkg::ST_IDLE;
         end
         default: begin
            state_in = bwa_pkg::ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs
   always_comb begin
      busy      = 1'b1;
      div_start = 1'b0;
      rd_en     = 1'b0;
      set_clear = 1'b0;
      case (state_ff)
         bwa_pkg::ST_IDLE:      busy      = 1'b0;
         bwa_pkg::ST_DIV_START: div_start = 1'b1;
         bwa_pkg::ST_DIV_WAIT:  busy      = 1'b1;
         bwa_pkg::ST_EMIT:      rd_en     = 1'b1;
         bwa_pkg::ST_DRAIN:     set_clear = 1'b1;
         default:               busy      = 1'b1;
      endcase
   end

   // Accumulate while loading; drop samples past capacity and flag the set.
   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (set_clear) begin
         sum_in   = '0;
         count_in = '0;
         ovf_in   = 1'b0;
      end else if (accept) begin
         if (room) begin
            sum_in   = sum_ff + SUM_W'(sample_mag);
            count_in = count_ff + CNT_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   // Walk the sign memory once alpha is known.
   always_comb begin
      rd_idx_in   = rd_en ? (rd_idx_ff + CNT_W'(1)) : '0;
      rd_valid_in = rd_en;
      rd_last_in  = rd_en && last_read;
      alpha_in    = div_done ? div_quotient[SW-1:0] : alpha_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= bwa_pkg::ST_IDLE;
         sum_ff      <= '0;
         count_ff    <= '0;
         ovf_ff      <= 1'b0;
         rd_idx_ff   <= '0;
         rd_valid_ff <= 1'b0;
         rd_last_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         sum_ff      <= sum_in;
         count_ff    <= count_in;
         ovf_ff      <= ovf_in;
         rd_idx_ff   <= rd_idx_in;
         rd_valid_ff <= rd_valid_in;
         rd_last_ff  <= rd_last_in;
      end
      alpha_ff <= alpha_in;
   end

   // Sign memory: store 1 for a zero or positive sample.
   always_ff @(posedge clock) begin
      if (accept && room) begin
         sign_mem[count_ff[ADDR_W-1:0]] <= !sample_neg;
      end
      if (rd_en) begin
         sign_q_ff <= sign_mem[rd_idx_ff[ADDR_W-1:0]];
      end
   end

   // alpha = floor(sum / count); count is at least one at the end of a set.
   bwa_divider #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (CNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Drive the result from the read register; negate alpha for negative signs.
   assign alpha_ext           = {1'b0, alpha_ff};
   assign rsp_strobe          = rd_valid_ff;
   assign rsp_data.scaled     = sign_q_ff ? alpha_ext : (~alpha_ext + (SW + 1)'(1));
   assign rsp_data.positive   = sign_q_ff;
   assign rsp_data.last_out   = rd_last_ff;
   assign rsp_data.overflowed = ovf_ff;

   a_strobe_in_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (state_ff == bwa_pkg::ST_EMIT || state_ff == bwa_pkg::ST_DRAIN))
      else $error("result strobe outside the emit phase");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ELEMS))
      else $error("element count beyond capacity");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.last_out) |=>
         (state_ff == bwa_pkg::ST_IDLE && count_ff == '0 && !ovf_ff))
      else $error("set not cleared after final result");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bwa_pkg::ST_DIV_START) |-> (count_ff != '0))
      else $error("set ended with no stored samples");

endmodule

`default_nettype wire

FILE: rtl/bwa_divider.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module bwa_divider #(
   parameter int DIVIDEND_W = 22,
   parameter int DIVISOR_W  = 7
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       done,
   output logic [DIVIDEND_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  running_ff, running_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;

   logic [DIVISOR_W:0]    rem_shift;
   logic [DIVISOR_W:0]    rem_sub;
   logic                  fits;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIVIDEND_W-1]};
      fits      = rem_shift >= {1'b0, divisor_ff};
      rem_sub   = rem_shift - {1'b0, divisor_ff};

      running_in = running_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;

      if (start) begin
         running_in = 1'b1;
         cnt_in     = CNT_W'(DIVIDEND_W);
         quo_in     = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (running_ff) begin
         // shift in one dividend bit, subtract when the divisor fits
         rem_in = fits ? rem_sub[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         cnt_ff     <= cnt_in;
      end
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ($past(running_ff) && !running_ff))
      else $error("divider done without a preceding run");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (running_ff && divisor_ff != '0) |-> (rem_ff < divisor_ff))
      else $error("divider remainder not below divisor");

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      start |=> (running_ff && cnt_ff == CNT_W'(DIVIDEND_W)))
      else $error("divider did not load on start");

endmodule

`default_nettype wire
